// File: rtl/core/i2cm_pkg.sv
// Shared types, register map and constants of the I2C master register block.
`default_nettype none

package i2cm_pkg;

    // Receive FIFO geometry.
    localparam int RX_FIFO_DEPTH = 16;
    localparam int RX_IDX_W      = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int RX_CNT_W      = $clog2(RX_FIFO_DEPTH + 1);

    // Register widths.
    localparam int CR1_W = 16;
    localparam int CR2_W = 11;
    localparam int SR1_W = 11;
    localparam int SR2_W = 3;

    // Access kinds carried by an input beat.
    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_INJECT = 2'd2
    } kind_t;

    // Register byte offsets.
    localparam logic [5:0] OFS_CR1   = 6'h00;
    localparam logic [5:0] OFS_CR2   = 6'h04;
    localparam logic [5:0] OFS_OAR1  = 6'h08;
    localparam logic [5:0] OFS_OAR2  = 6'h0C;
    localparam logic [5:0] OFS_DR    = 6'h10;
    localparam logic [5:0] OFS_SR1   = 6'h14;
    localparam logic [5:0] OFS_SR2   = 6'h18;
    localparam logic [5:0] OFS_CCR   = 6'h1C;
    localparam logic [5:0] OFS_TRISE = 6'h20;
    localparam logic [5:0] OFS_FLTR  = 6'h24;

    // CR1 bit positions.
    localparam int C1_START = 8;
    localparam int C1_STOP  = 9;
    localparam int C1_SWRST = 15;

    // SR1 bit positions.
    localparam int S1_SB   = 0;
    localparam int S1_ADDR = 1;
    localparam int S1_BTF  = 2;
    localparam int S1_RXNE = 6;
    localparam int S1_TXE  = 7;
    localparam int S1_BERR = 8;
    localparam int S1_AF   = 10;

    // SR2 bit positions.
    localparam int S2_MSL  = 0;
    localparam int S2_BUSY = 1;
    localparam int S2_TRA  = 2;

    // Reset values.
    localparam logic [SR1_W-1:0] SR1_RESET   = SR1_W'(11'h080);
    localparam logic [31:0]      TRISE_RESET = 32'd2;

    // Requests from the register logic to the receive FIFO.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_data;
    } rx_cmd_t;

    // Status of the receive FIFO seen by the register logic.
    typedef struct packed {
        logic [RX_CNT_W-1:0] count;
        logic                empty;
        logic                full;
        logic [7:0]          head_data;
    } rx_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/i2cm_if.sv
// Valid/ready channel interfaces for the access beats and the result beats.
`default_nettype none

interface i2cm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  reg_offset;
    logic [31:0] write_value;
    logic [7:0]  inject_byte;

    modport source (output valid, kind, reg_offset, write_value, inject_byte, input ready);
    modport sink   (input valid, kind, reg_offset, write_value, inject_byte, output ready);
endinterface

interface i2cm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        inject_accepted;

    modport source (output valid, read_data, tx_valid, tx_byte, inject_accepted, input ready);
    modport sink   (input valid, read_data, tx_valid, tx_byte, inject_accepted, output ready);
endinterface

`default_nettype wire

// File: rtl/core/i2cm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read of the address being written
    // returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/i2cm_rx_fifo.sv
// Receive FIFO: head and fill count, storage RAM and a head-of-queue read path.
`default_nettype none

module i2cm_rx_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire i2cm_pkg::rx_cmd_t cmd,
    output i2cm_pkg::rx_stat_t     stat
);

    localparam int IW = i2cm_pkg::RX_IDX_W;
    localparam int CW = i2cm_pkg::RX_CNT_W;

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          bypass_reg, bypass_next;
    logic [7:0]    bypass_data_reg;
    logic [IW:0]   wr_sum;
    logic [IW-1:0] wr_addr;
    logic [7:0]    ram_rd;

    // Tail address is head plus count, wrapped once around the depth.
    always_comb
    begin
        wr_sum = {1'b0, head_reg} + (IW + 1)'(count_reg);
        if (wr_sum >= (IW + 1)'(i2cm_pkg::RX_FIFO_DEPTH))
        begin
            wr_sum = wr_sum - (IW + 1)'(i2cm_pkg::RX_FIFO_DEPTH);
        end
        wr_addr = wr_sum[IW-1:0];
    end

    // Head and count advance; a beat never pushes and pops at once.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            if (head_reg == IW'(i2cm_pkg::RX_FIFO_DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + IW'(1);
            end
            count_next = count_reg - CW'(1);
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        // The RAM returns old data when the new head is written this cycle.
        bypass_next = cmd.push && (wr_addr == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            bypass_reg <= bypass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_data_reg <= cmd.push_data;
    end

    // The RAM always reads the next head so its data is ready for the next beat.
    i2cm_ram #(
        .WIDTH (8),
        .DEPTH (i2cm_pkg::RX_FIFO_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (wr_addr),
        .wr_data (cmd.push_data),
        .rd_addr (head_next),
        .rd_data (ram_rd)
    );

    assign stat.count     = count_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(i2cm_pkg::RX_FIFO_DEPTH));
    assign stat.head_data = bypass_reg ? bypass_data_reg : ram_rd;

endmodule

`default_nettype wire

// File: rtl/core/i2c_master_register_model_unit.sv
// Result: a beat's result is registered when the beat advances out of the input stage.
// Throughput: one access beat per cycle; the input and result registers keep
// accepting while a finished result waits, and stall only when both are full.
// Reset: rst_n clears all architectural registers to their documented reset values (SR1 = TXE,
// TRISE = 2) and empties the receive FIFO; FIFO storage itself is not cleared.
`default_nettype none

module i2c_master_register_model_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    i2cm_in_if.sink    in_ch,
    i2cm_out_if.source out_ch
);

    // Input stage.
    logic                in_vld_reg;
    i2cm_pkg::kind_t     kind_reg;
    logic [5:0]          ofs_reg;
    logic [31:0]         wval_reg;
    logic [7:0]          ibyte_reg;

    // Result stage.
    logic                out_vld_reg;
    logic [31:0]         rd_reg, rd_next;
    logic                txv_reg, txv_next;
    logic [7:0]          txb_reg, txb_next;
    logic                acc_reg, acc_next;

    // Architectural registers.
    logic [i2cm_pkg::CR1_W-1:0] cr1_reg, cr1_next;
    logic [i2cm_pkg::CR2_W-1:0] cr2_reg, cr2_next;
    logic [31:0]                oar1_reg, oar1_next;
    logic [31:0]                oar2_reg, oar2_next;
    logic [i2cm_pkg::SR1_W-1:0] sr1_reg, sr1_next;
    logic [i2cm_pkg::SR2_W-1:0] sr2_reg, sr2_next;
    logic [31:0]                ccr_reg, ccr_next;
    logic [31:0]                trise_reg, trise_next;
    logic [31:0]                fltr_reg, fltr_next;

    i2cm_pkg::rx_cmd_t  rx_cmd;
    i2cm_pkg::rx_stat_t rx_stat;
    logic               advance;

    // Handshake: the input stage moves on when the result stage is free.
    assign advance      = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready  = !in_vld_reg || advance;
    assign out_ch.valid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_vld_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            kind_reg  <= i2cm_pkg::kind_t'(in_ch.kind);
            ofs_reg   <= in_ch.reg_offset;
            wval_reg  <= in_ch.write_value;
            ibyte_reg <= in_ch.inject_byte;
        end
        if (advance)
        begin
            rd_reg  <= rd_next;
            txv_reg <= txv_next;
            txb_reg <= txb_next;
            acc_reg <= acc_next;
        end
    end

    // Register access logic for the beat in the input stage.
    always_comb
    begin
        cr1_next   = cr1_reg;
        cr2_next   = cr2_reg;
        oar1_next  = oar1_reg;
        oar2_next  = oar2_reg;
        sr1_next   = sr1_reg;
        sr2_next   = sr2_reg;
        ccr_next   = ccr_reg;
        trise_next = trise_reg;
        fltr_next  = fltr_reg;
        rd_next    = '0;
        txv_next   = 1'b0;
        txb_next   = '0;
        acc_next   = 1'b0;
        rx_cmd     = '0;
        rx_cmd.push_data = ibyte_reg;

        unique case (kind_reg)
            i2cm_pkg::KIND_READ:
            begin
                unique case (ofs_reg)
                    i2cm_pkg::OFS_CR1:   rd_next = 32'(cr1_reg);
                    i2cm_pkg::OFS_CR2:   rd_next = 32'(cr2_reg);
                    i2cm_pkg::OFS_OAR1:  rd_next = oar1_reg;
                    i2cm_pkg::OFS_OAR2:  rd_next = oar2_reg;
                    i2cm_pkg::OFS_DR:
                    begin
                        // Pop when not empty; RXNE drops once the FIFO drains.
                        if (!rx_stat.empty)
                        begin
                            rx_cmd.pop = 1'b1;
                            rd_next    = 32'(rx_stat.head_data);
                        end
                        if (rx_stat.empty || (rx_stat.count == i2cm_pkg::RX_CNT_W'(1)))
                        begin
                            sr1_next[i2cm_pkg::S1_RXNE] = 1'b0;
                        end
                    end
                    i2cm_pkg::OFS_SR1:   rd_next = 32'(sr1_reg);
                    i2cm_pkg::OFS_SR2:
                    begin
                        sr1_next[i2cm_pkg::S1_ADDR] = 1'b0;
                        rd_next = 32'(sr2_reg);
                    end
                    i2cm_pkg::OFS_CCR:   rd_next = ccr_reg;
                    i2cm_pkg::OFS_TRISE: rd_next = trise_reg;
                    i2cm_pkg::OFS_FLTR:  rd_next = fltr_reg;
                    default:             rd_next = '0;
                endcase
            end
            i2cm_pkg::KIND_WRITE:
            begin
                unique case (ofs_reg)
                    i2cm_pkg::OFS_CR1:
                    begin
                        if (wval_reg[i2cm_pkg::C1_SWRST])
                        begin
                            // Software reset clears CR1, SR1 and SR2.
                            cr1_next = '0;
                            sr1_next = '0;
                            sr2_next = '0;
                        end
                        else
                        begin
                            // START and STOP act once and never read back.
                            cr1_next = wval_reg[i2cm_pkg::CR1_W-1:0];
                            cr1_next[i2cm_pkg::C1_START] = 1'b0;
                            cr1_next[i2cm_pkg::C1_STOP]  = 1'b0;
                            if (wval_reg[i2cm_pkg::C1_START])
                            begin
                                sr1_next[i2cm_pkg::S1_SB]   = 1'b1;
                                sr2_next[i2cm_pkg::S2_MSL]  = 1'b1;
                                sr2_next[i2cm_pkg::S2_BUSY] = 1'b1;
                            end
                            if (wval_reg[i2cm_pkg::C1_STOP])
                            begin
                                sr2_next = '0;
                                sr1_next[i2cm_pkg::S1_TXE] = 1'b0;
                                sr1_next[i2cm_pkg::S1_BTF] = 1'b0;
                            end
                        end
                    end
                    i2cm_pkg::OFS_CR2:   cr2_next  = wval_reg[i2cm_pkg::CR2_W-1:0];
                    i2cm_pkg::OFS_OAR1:  oar1_next = wval_reg;
                    i2cm_pkg::OFS_OAR2:  oar2_next = wval_reg;
                    i2cm_pkg::OFS_DR:
                    begin
                        if (sr1_reg[i2cm_pkg::S1_SB])
                        begin
                            // Address phase: bit 0 picks the direction.
                            sr1_next[i2cm_pkg::S1_SB]   = 1'b0;
                            sr1_next[i2cm_pkg::S1_ADDR] = 1'b1;
                            sr1_next[i2cm_pkg::S1_TXE]  = 1'b1;
                            sr2_next[i2cm_pkg::S2_TRA]  = !wval_reg[0];
                        end
                        else
                        begin
                            sr1_next[i2cm_pkg::S1_TXE] = 1'b1;
                            sr1_next[i2cm_pkg::S1_BTF] = 1'b1;
                            txv_next = 1'b1;
                            txb_next = wval_reg[7:0];
                        end
                    end
                    i2cm_pkg::OFS_SR1:
                    begin
                        // Only the error flags clear, by writing zero.
                        if (!wval_reg[i2cm_pkg::S1_AF])
                        begin
                            sr1_next[i2cm_pkg::S1_AF] = 1'b0;
                        end
                        if (!wval_reg[i2cm_pkg::S1_BERR])
                        begin
                            sr1_next[i2cm_pkg::S1_BERR] = 1'b0;
                        end
                    end
                    i2cm_pkg::OFS_CCR:   ccr_next   = wval_reg;
                    i2cm_pkg::OFS_TRISE: trise_next = wval_reg;
                    i2cm_pkg::OFS_FLTR:  fltr_next  = wval_reg;
                    default:             ccr_next   = ccr_reg;
                endcase
            end
            i2cm_pkg::KIND_INJECT:
            begin
                if (!rx_stat.full)
                begin
                    rx_cmd.push = 1'b1;
                    sr1_next[i2cm_pkg::S1_RXNE] = 1'b1;
                    acc_next = 1'b1;
                end
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase

        // Nothing changes unless the beat moves to the result stage.
        if (!advance)
        begin
            rx_cmd.push = 1'b0;
            rx_cmd.pop  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr1_reg   <= '0;
            cr2_reg   <= '0;
            oar1_reg  <= '0;
            oar2_reg  <= '0;
            sr1_reg   <= i2cm_pkg::SR1_RESET;
            sr2_reg   <= '0;
            ccr_reg   <= '0;
            trise_reg <= i2cm_pkg::TRISE_RESET;
            fltr_reg  <= '0;
        end
        else if (advance)
        begin
            cr1_reg   <= cr1_next;
            cr2_reg   <= cr2_next;
            oar1_reg  <= oar1_next;
            oar2_reg  <= oar2_next;
            sr1_reg   <= sr1_next;
            sr2_reg   <= sr2_next;
            ccr_reg   <= ccr_next;
            trise_reg <= trise_next;
            fltr_reg  <= fltr_next;
        end
    end

    i2cm_rx_fifo u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rx_cmd),
        .stat  (rx_stat)
    );

    assign out_ch.read_data       = rd_reg;
    assign out_ch.tx_valid        = txv_reg;
    assign out_ch.tx_byte         = txb_reg;
    assign out_ch.inject_accepted = acc_reg;

    // The FIFO fill count never exceeds its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stat.count <= i2cm_pkg::RX_CNT_W'(i2cm_pkg::RX_FIFO_DEPTH))
        else $error("receive FIFO count above depth");

    // RXNE is never set while the FIFO is empty.
    a_rxne_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stat.empty |-> !sr1_reg[i2cm_pkg::S1_RXNE])
        else $error("RXNE set with empty receive FIFO");

    // START and STOP never remain stored in CR1.
    a_cr1_selfclear: assert property (@(posedge clk) disable iff (!rst_n)
        !cr1_reg[i2cm_pkg::C1_START] && !cr1_reg[i2cm_pkg::C1_STOP])
        else $error("START or STOP stored in CR1");

    // The input side only stalls when both stages hold a beat.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (in_vld_reg && out_vld_reg))
        else $error("input stalled with a free stage");

    // The FIFO count moves only when a beat advances.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(rx_stat.count))
        else $error("receive FIFO count changed without a beat");

endmodule

`default_nettype wire
